// File: rtl/mhs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the max heap sort engine
// no dependencies

package mhs_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int WORD_BITS_DEF = 32;
    localparam logic [10:0] CAP_RESET = 11'd1024;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        REQ_CLEAR = 3'd0,
        REQ_LOAD  = 3'd1,
        REQ_ADD   = 3'd2,
        REQ_SORT  = 3'd3,
        REQ_READ  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_SORTED = 2'd2,
        ST_INDEX  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        A_INDEX = 4'd0,
        A_COUNT = 4'd1,
        A_C     = 4'd2,
        A_PAR_C = 4'd3,
        A_ZERO  = 4'd4,
        A_N     = 4'd5,
        A_PAR   = 4'd6,
        A_LEFT  = 4'd7,
        A_RIGHT = 4'd8,
        A_SEL   = 4'd9
    } t_addr_sel;

    typedef enum logic [2:0] {
        W_VALUE = 3'd0,
        W_X     = 3'd1,
        W_PW    = 3'd2,
        W_LW    = 3'd3,
        W_RD    = 3'd4
    } t_wsel;

    typedef struct packed {
        logic      acc;
        logic      we;
        t_addr_sel addr_sel;
        t_wsel     wsel;
        logic      lat_pw;
        logic      lat_lw;
        logic      lat_sel;
        logic      sel_right;
        logic      c_to_par;
        logic      adj_init;
        logic      left_step;
        logic      set_changed;
        logic      n_dec;
        logic      set_sorted;
        logic      fin_acc;
        logic      fin_late;
        logic      late_read;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       sorted;
        logic       idx_ok;
        logic       last;
        logic       c_zero;
        logic       x_le_p;
        logic       n_lt2;
        logic       n_zero;
        logic       left_lt2;
        logic       changed;
        logic       l_gt_p;
        logic       r_gt_p;
    } t_stat;

endpackage

// File: rtl/max_heap_sort_engine.sv
`timescale 1ns / 1ps
// top level of the max heap sort engine: config register, controller, datapath
// depends on mhs_pkg, mhs_ctrl, mhs_dp
//
// usage: a request (i_req_type, i_value, i_index, i_last_of_load) is taken at a
// rising edge with start high and busy low. every request gives one result on
// o_status, o_read_value, o_entry_count and o_sorted_mark, shown for one cycle
// with o_done high; the receiver cannot hold results off, so none is dropped.
// clear, non-final load, refused and unknown requests give their result in the
// cycle after the request, and busy stays low so the next request may follow
// at once. a read waits in S_RD_WAIT for the registered word. add compares and
// writes per level the word rises, until a parent is at least as large or it
// is the root. a final load runs adjustment passes that read parent, left and
// right of each child pair and write both on a swap, until a pass is clean;
// sort swaps root and last entry per entry, then adjusts the shrinking heap.
// the single heap memory port, one access per cycle, paces these steps. capacity
// is to be written over the apb port only while idle, which the block does not
// enforce (pready always high). reset clears count, sorted mark and controller;
// capacity returns to 1024; heap memory is not cleared and needs no clearing pass.

module max_heap_sort_engine #(
    parameter int DEPTH     = mhs_pkg::DEPTH_DEF,
    parameter int WORD_BITS = mhs_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value,
    input  logic [9:0]         i_index,
    input  logic               i_last_of_load,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [10:0]        o_entry_count,
    output logic               o_sorted_mark
);

    logic [10:0]    r_cap;
    mhs_pkg::t_cmd  cmd;
    mhs_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= mhs_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == mhs_pkg::REG_CAPACITY) begin
            r_cap <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mhs_pkg::REG_CAPACITY) ? {21'd0, r_cap} : 32'd0;

    mhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mhs_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_index        (i_index),
        .i_last_of_load (i_last_of_load),
        .i_cap          (r_cap),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_read_value   (o_read_value),
        .o_entry_count  (o_entry_count),
        .o_sorted_mark  (o_sorted_mark)
    );

endmodule

// File: rtl/mhs_ram.sv
`timescale 1ns / 1ps
// generic single port ram with registered read
// no dependencies

module mhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mhs_dp.sv
`timescale 1ns / 1ps
// datapath: heap store, count, indexes, word registers and result registers
// depends on mhs_pkg and mhs_ram

module mhs_dp #(
    parameter int DEPTH     = mhs_pkg::DEPTH_DEF,
    parameter int WORD_BITS = mhs_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mhs_pkg::t_cmd       i_cmd,
    output mhs_pkg::t_stat      o_stat,
    input  logic [2:0]          i_req_type,
    input  logic signed [31:0]  i_value,
    input  logic [9:0]          i_index,
    input  logic                i_last_of_load,
    input  logic [10:0]         i_cap,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_read_value,
    output logic [10:0]         o_entry_count,
    output logic                o_sorted_mark
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0]        r_count, n_count, r_n, r_left, r_c, r_sel;
    logic                 r_sorted, n_sorted, r_changed;
    logic [WORD_BITS-1:0] r_x, r_pw, r_lw, w_in, rd, wdata;
    logic [1:0]           r_status, a_status;
    logic [AW-1:0]        addr;
    logic [CW-1:0]        par_c, par_l, right;
    logic                 full, idx_ok, right_ok;
    logic                 r_done;
    logic [1:0]           r_o_status;
    logic signed [31:0]   r_o_value;
    logic [10:0]          r_o_count;
    logic                 r_o_sorted;

    assign w_in     = WORD_BITS'(i_value);
    assign full     = (32'(r_count) >= 32'(i_cap)) || (32'(r_count) >= 32'(DEPTH));
    assign idx_ok   = (32'(i_index) < 32'(r_count)) && (32'(i_index) < 32'(DEPTH));
    assign par_c    = (r_c - CW'(1)) >> 1;
    assign par_l    = (r_left - CW'(1)) >> 1;
    assign right    = r_left + CW'(1);
    assign right_ok = right < r_n;

    always_comb begin
        n_count  = r_count;
        n_sorted = r_sorted;
        a_status = mhs_pkg::ST_OK;
        if (i_cmd.acc) begin
            case (i_req_type)
                mhs_pkg::REQ_CLEAR: begin
                    n_count  = '0;
                    n_sorted = 1'b0;
                end
                mhs_pkg::REQ_LOAD: begin
                    if (full) begin
                        a_status = mhs_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                mhs_pkg::REQ_ADD: begin
                    if (r_sorted) begin
                        a_status = mhs_pkg::ST_SORTED;
                    end else if (full) begin
                        a_status = mhs_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                mhs_pkg::REQ_READ: begin
                    if (!idx_ok) begin
                        a_status = mhs_pkg::ST_INDEX;
                    end
                end
                default: a_status = mhs_pkg::ST_OK;
            endcase
        end
        if (i_cmd.set_sorted) begin
            n_sorted = 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.addr_sel)
            mhs_pkg::A_INDEX: addr = AW'(i_index);
            mhs_pkg::A_COUNT: addr = AW'(r_count);
            mhs_pkg::A_C:     addr = AW'(r_c);
            mhs_pkg::A_PAR_C: addr = AW'(par_c);
            mhs_pkg::A_N:     addr = AW'(r_n);
            mhs_pkg::A_PAR:   addr = AW'(par_l);
            mhs_pkg::A_LEFT:  addr = AW'(r_left);
            mhs_pkg::A_RIGHT: addr = AW'(right);
            mhs_pkg::A_SEL:   addr = AW'(r_sel);
            default:          addr = '0;
        endcase
        case (i_cmd.wsel)
            mhs_pkg::W_VALUE: wdata = w_in;
            mhs_pkg::W_X:     wdata = r_x;
            mhs_pkg::W_PW:    wdata = r_pw;
            mhs_pkg::W_LW:    wdata = r_lw;
            default:          wdata = rd;
        endcase
    end

    mhs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sorted <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_sorted <= n_sorted;
            r_done   <= i_cmd.fin_acc | i_cmd.fin_late;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_status <= a_status;
            r_n      <= n_count;
            r_c      <= r_count;
            r_x      <= w_in;
        end
        if (i_cmd.c_to_par) begin
            r_c <= par_c;
        end
        if (i_cmd.adj_init) begin
            r_left    <= r_n[0] ? r_n - CW'(2) : r_n - CW'(1);
            r_changed <= 1'b0;
        end
        if (i_cmd.left_step) begin
            r_left <= r_left - CW'(2);
        end
        if (i_cmd.set_changed) begin
            r_changed <= 1'b1;
        end
        if (i_cmd.n_dec) begin
            r_n <= r_n - CW'(1);
        end
        if (i_cmd.lat_pw) begin
            r_pw <= rd;
        end
        if (i_cmd.lat_lw) begin
            r_lw <= rd;
        end
        if (i_cmd.lat_sel) begin
            r_sel <= i_cmd.sel_right ? right : r_left;
        end
        if (i_cmd.fin_acc) begin
            r_o_status <= a_status;
            r_o_value  <= '0;
            r_o_count  <= 11'(n_count);
            r_o_sorted <= n_sorted;
        end else if (i_cmd.fin_late) begin
            r_o_status <= r_status;
            r_o_value  <= i_cmd.late_read ? 32'($signed(rd)) : 32'sd0;
            r_o_count  <= 11'(n_count);
            r_o_sorted <= n_sorted;
        end
    end

    assign o_stat.req      = i_req_type;
    assign o_stat.full     = full;
    assign o_stat.sorted   = r_sorted;
    assign o_stat.idx_ok   = idx_ok;
    assign o_stat.last     = i_last_of_load;
    assign o_stat.c_zero   = (r_c == '0);
    assign o_stat.x_le_p   = $signed(r_x) <= $signed(rd);
    assign o_stat.n_lt2    = r_n < CW'(2);
    assign o_stat.n_zero   = (r_n == '0);
    assign o_stat.left_lt2 = r_left < CW'(2);
    assign o_stat.changed  = r_changed;
    assign o_stat.l_gt_p   = $signed(r_lw) > $signed(r_pw);
    assign o_stat.r_gt_p   = right_ok && ($signed(rd) > $signed(r_pw));

    assign o_done        = r_done;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_value;
    assign o_entry_count = r_o_count;
    assign o_sorted_mark = r_o_sorted;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc && i_req_type == mhs_pkg::REQ_CLEAR) |=> (r_count == '0 && !r_sorted))
        else $error("clear left entries or sorted mark");

    a_count_drops_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < $past(r_count)) |-> $past(i_cmd.acc && i_req_type == mhs_pkg::REQ_CLEAR))
        else $error("count fell without a clear");

    a_sorted_rises_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sorted) |-> $past(i_cmd.set_sorted && i_cmd.fin_late))
        else $error("sorted mark set outside sort completion");

    a_append_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.we && i_cmd.addr_sel == mhs_pkg::A_COUNT) |-> !full)
        else $error("append written past capacity");

endmodule

// File: rtl/mhs_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences clear, load, add, adjustment, sort and read
// depends on mhs_pkg

module mhs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  mhs_pkg::t_stat i_stat,
    output mhs_pkg::t_cmd  o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_RD_WAIT   = 15'h0002,
        S_ADD_RD    = 15'h0004,
        S_ADD_CMP   = 15'h0008,
        S_ADJ_START = 15'h0010,
        S_ADJ_RP    = 15'h0020,
        S_ADJ_RL    = 15'h0040,
        S_ADJ_RR    = 15'h0080,
        S_ADJ_CMP   = 15'h0100,
        S_ADJ_WR2   = 15'h0200,
        S_SORT_STEP = 15'h0400,
        S_SORT_RA   = 15'h0800,
        S_SORT_RB   = 15'h1000,
        S_SORT_W1   = 15'h2000,
        S_SORT_W2   = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   r_sorting, n_sorting;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_sorting = r_sorting;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.acc = 1'b1;
                    case (i_stat.req)
                        mhs_pkg::REQ_LOAD: begin
                            o_cmd.addr_sel = mhs_pkg::A_COUNT;
                            o_cmd.wsel     = mhs_pkg::W_VALUE;
                            o_cmd.we       = !i_stat.full;
                            if (i_stat.last) begin
                                n_sorting = 1'b0;
                                n_state   = S_ADJ_START;
                            end else begin
                                o_cmd.fin_acc = 1'b1;
                            end
                        end
                        mhs_pkg::REQ_ADD: begin
                            if (i_stat.sorted || i_stat.full) begin
                                o_cmd.fin_acc = 1'b1;
                            end else begin
                                n_state = S_ADD_RD;
                            end
                        end
                        mhs_pkg::REQ_SORT: begin
                            n_sorting = 1'b1;
                            n_state   = S_SORT_STEP;
                        end
                        mhs_pkg::REQ_READ: begin
                            if (i_stat.idx_ok) begin
                                o_cmd.addr_sel = mhs_pkg::A_INDEX;
                                n_state        = S_RD_WAIT;
                            end else begin
                                o_cmd.fin_acc = 1'b1;
                            end
                        end
                        default: o_cmd.fin_acc = 1'b1;
                    endcase
                end
            end
            S_RD_WAIT: begin
                o_cmd.fin_late  = 1'b1;
                o_cmd.late_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_ADD_RD: begin
                if (i_stat.c_zero) begin
                    o_cmd.we       = 1'b1;
                    o_cmd.addr_sel = mhs_pkg::A_C;
                    o_cmd.wsel     = mhs_pkg::W_X;
                    o_cmd.fin_late = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.addr_sel = mhs_pkg::A_PAR_C;
                    n_state        = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                o_cmd.we       = 1'b1;
                o_cmd.addr_sel = mhs_pkg::A_C;
                if (i_stat.x_le_p) begin
                    o_cmd.wsel     = mhs_pkg::W_X;
                    o_cmd.fin_late = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.wsel     = mhs_pkg::W_RD;
                    o_cmd.c_to_par = 1'b1;
                    n_state        = S_ADD_RD;
                end
            end
            S_ADJ_START: begin
                if (i_stat.n_lt2) begin
                    if (r_sorting) begin
                        n_state = S_SORT_STEP;
                    end else begin
                        o_cmd.fin_late = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.adj_init = 1'b1;
                    n_state        = S_ADJ_RP;
                end
            end
            S_ADJ_RP: begin
                o_cmd.addr_sel = mhs_pkg::A_PAR;
                n_state        = S_ADJ_RL;
            end
            S_ADJ_RL: begin
                o_cmd.addr_sel = mhs_pkg::A_LEFT;
                o_cmd.lat_pw   = 1'b1;
                n_state        = S_ADJ_RR;
            end
            S_ADJ_RR: begin
                o_cmd.addr_sel = mhs_pkg::A_RIGHT;
                o_cmd.lat_lw   = 1'b1;
                n_state        = S_ADJ_CMP;
            end
            S_ADJ_CMP: begin
                o_cmd.addr_sel = mhs_pkg::A_PAR;
                if (i_stat.l_gt_p) begin
                    o_cmd.we      = 1'b1;
                    o_cmd.wsel    = mhs_pkg::W_LW;
                    o_cmd.lat_sel = 1'b1;
                    n_state       = S_ADJ_WR2;
                end else if (i_stat.r_gt_p) begin
                    o_cmd.we        = 1'b1;
                    o_cmd.wsel      = mhs_pkg::W_RD;
                    o_cmd.lat_sel   = 1'b1;
                    o_cmd.sel_right = 1'b1;
                    n_state         = S_ADJ_WR2;
                end else if (!i_stat.left_lt2) begin
                    o_cmd.left_step = 1'b1;
                    n_state         = S_ADJ_RP;
                end else if (i_stat.changed) begin
                    n_state = S_ADJ_START;
                end else if (r_sorting) begin
                    n_state = S_SORT_STEP;
                end else begin
                    o_cmd.fin_late = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ADJ_WR2: begin
                o_cmd.we          = 1'b1;
                o_cmd.addr_sel    = mhs_pkg::A_SEL;
                o_cmd.wsel        = mhs_pkg::W_PW;
                o_cmd.set_changed = 1'b1;
                if (i_stat.left_lt2) begin
                    n_state = S_ADJ_START;
                end else begin
                    o_cmd.left_step = 1'b1;
                    n_state         = S_ADJ_RP;
                end
            end
            S_SORT_STEP: begin
                if (i_stat.n_zero) begin
                    o_cmd.set_sorted = 1'b1;
                    o_cmd.fin_late   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.n_dec = 1'b1;
                    n_state     = S_SORT_RA;
                end
            end
            S_SORT_RA: begin
                o_cmd.addr_sel = mhs_pkg::A_ZERO;
                n_state        = S_SORT_RB;
            end
            S_SORT_RB: begin
                o_cmd.addr_sel = mhs_pkg::A_N;
                o_cmd.lat_pw   = 1'b1;
                n_state        = S_SORT_W1;
            end
            S_SORT_W1: begin
                o_cmd.we       = 1'b1;
                o_cmd.addr_sel = mhs_pkg::A_ZERO;
                o_cmd.wsel     = mhs_pkg::W_RD;
                n_state        = S_SORT_W2;
            end
            S_SORT_W2: begin
                o_cmd.we       = 1'b1;
                o_cmd.addr_sel = mhs_pkg::A_N;
                o_cmd.wsel     = mhs_pkg::W_PW;
                n_state        = S_ADJ_START;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sorting <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sorting <= n_sorting;
        end
    end

endmodule

// File: test/mhs_checker.sv
`timescale 1ns / 1ps
// checker of the max heap sort engine: watches requests, apb writes and results,
// keeps its own heap copy, predicts each result and compares it field by field
// depends on mhs_pkg

module mhs_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value,
    input  logic [9:0]         i_index,
    input  logic               i_last_of_load,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               o_done,
    input  logic [1:0]         o_status,
    input  logic signed [31:0] o_read_value,
    input  logic [10:0]        o_entry_count,
    input  logic               o_sorted_mark,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int HEAP_DEPTH = 1024;

    typedef struct {
        mhs_pkg::t_status   status;
        logic signed [31:0] read_value;
        logic [10:0]        entry_count;
        logic               sorted_mark;
    } t_heap_result;

    logic signed [31:0] heap_mem [HEAP_DEPTH];
    int                 held;
    logic               sorted_flag;
    logic [10:0]        cap_reg;
    t_heap_result       result_q [$];

    assign o_pending = result_q.size();

    function automatic int room();
        return (cap_reg > HEAP_DEPTH) ? HEAP_DEPTH : int'(cap_reg);
    endfunction

    task automatic swap_entries(input int a, input int b);
        logic signed [31:0] t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endtask

    // bottom-up passes over child pairs until one pass is clean
    task automatic settle_heap(input int n);
        bit changed;
        int left;
        int parent;
        changed = 1;
        while (changed && n >= 2) begin
            changed = 0;
            left = (n % 2 == 0) ? n - 1 : n - 2;
            while (left > 0) begin
                parent = (left - 1) / 2;
                if (heap_mem[left] > heap_mem[parent]) begin
                    swap_entries(left, parent);
                    changed = 1;
                end else if (left + 1 < n && heap_mem[left + 1] > heap_mem[parent]) begin
                    swap_entries(left + 1, parent);
                    changed = 1;
                end
                left = (left < 2) ? 0 : left - 2;
            end
        end
    endtask

    task automatic predict_request(input logic [2:0] rq, input logic signed [31:0] val,
                                   input logic [9:0] idx, input logic last,
                                   output t_heap_result r);
        int c;
        int p;
        int n;
        r.status = mhs_pkg::ST_OK;
        r.read_value = '0;
        case (rq)
            mhs_pkg::REQ_CLEAR: begin
                held = 0;
                sorted_flag = 1'b0;
            end
            mhs_pkg::REQ_LOAD: begin
                if (held < room()) begin
                    heap_mem[held] = val;
                    held++;
                end else begin
                    r.status = mhs_pkg::ST_FULL;
                end
                if (last) settle_heap(held);
            end
            mhs_pkg::REQ_ADD: begin
                if (sorted_flag) begin
                    r.status = mhs_pkg::ST_SORTED;
                end else if (held >= room()) begin
                    r.status = mhs_pkg::ST_FULL;
                end else begin
                    c = held;
                    heap_mem[c] = val;
                    held++;
                    while (c > 0) begin
                        p = (c - 1) / 2;
                        if (heap_mem[c] <= heap_mem[p]) break;
                        swap_entries(c, p);
                        c = p;
                    end
                end
            end
            mhs_pkg::REQ_SORT: begin
                n = held;
                while (n > 0) begin
                    n--;
                    swap_entries(0, n);
                    settle_heap(n);
                end
                sorted_flag = 1'b1;
            end
            mhs_pkg::REQ_READ: begin
                if (int'(idx) < held) r.read_value = heap_mem[idx];
                else r.status = mhs_pkg::ST_INDEX;
            end
            default: ;
        endcase
        r.entry_count = 11'(held);
        r.sorted_mark = sorted_flag;
    endtask

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_heap_result r;
        if (!i_rst_n) begin
            held = 0;
            sorted_flag = 1'b0;
            cap_reg = mhs_pkg::CAP_RESET;
            result_q.delete();
        end else begin
            if (o_done) begin
                if (result_q.size() == 0) begin
                    report("unexpected result", o_entry_count, -1);
                end else begin
                    r = result_q.pop_front();
                    if (o_status !== r.status) report("status", o_status, r.status);
                    if (o_read_value !== r.read_value)
                        report("read_value", o_read_value, r.read_value);
                    if (o_entry_count !== r.entry_count)
                        report("entry_count", o_entry_count, r.entry_count);
                    if (o_sorted_mark !== r.sorted_mark)
                        report("sorted_mark", o_sorted_mark, r.sorted_mark);
                end
            end
            if (psel && penable && pwrite && pready
                && paddr == 3'(mhs_pkg::REG_CAPACITY) * 3'd4)
                cap_reg = pwdata[10:0];
            if (start && !busy) begin
                predict_request(i_req_type, i_value, i_index, i_last_of_load, r);
                result_q.push_back(r);
            end
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench top of the max heap sort engine: clock, reset, request and apb stimulus
// depends on mhs_pkg, max_heap_sort_engine and mhs_checker

module tb;

    localparam int ITEM_GOAL = 650;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_req_type;
    logic signed [31:0] i_value;
    logic [9:0]         i_index;
    logic               i_last_of_load;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               o_done;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_value;
    logic [10:0]        o_entry_count;
    logic               o_sorted_mark;
    int                 errors;
    int                 pending;
    int                 issued;
    bit                 calm;

    max_heap_sort_engine i_dut (.*);

    mhs_checker i_chk (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 9)) - 32'sd5;
            default: return $signed($urandom);
        endcase
    endfunction

    // one request, held on the ports until the engine takes it
    task automatic issue(input logic [2:0] rq, input logic signed [31:0] val,
                         input logic [9:0] idx, input logic last);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= rq;
        i_value <= val;
        i_index <= idx;
        i_last_of_load <= last;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        issued++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [10:0] cap);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(mhs_pkg::REG_CAPACITY) * 3'd4;
        pwdata <= {21'($urandom_range(0, 2097151)), cap};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_words(input int k);
        for (int j = 0; j < k; j++) issue(mhs_pkg::REQ_LOAD, pick_word(), '0, j == k - 1);
    endtask

    task automatic random_round(input int cap);
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                issue(mhs_pkg::REQ_CLEAR, pick_word(), 10'($urandom), 1'b0);
                load_words($urandom_range(1, cap + 2));
            end
            3, 4: begin
                if ($urandom_range(0, 1)) issue(mhs_pkg::REQ_CLEAR, '0, '0, 1'b0);
                k = $urandom_range(1, cap + 2);
                for (int j = 0; j < k; j++)
                    issue(mhs_pkg::REQ_ADD, pick_word(), 10'($urandom), 1'b0);
            end
            5: issue(mhs_pkg::REQ_SORT, pick_word(), 10'($urandom), 1'b0);
            6: issue(mhs_pkg::REQ_LOAD, pick_word(), 10'($urandom), 1'($urandom));
            7: issue(3'($urandom_range(5, 7)), pick_word(), 10'($urandom), 1'($urandom));
            default: issue(mhs_pkg::REQ_ADD, pick_word(), '0, 1'b0);
        endcase
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++)
            issue(mhs_pkg::REQ_READ, pick_word(),
                  $urandom_range(0, 1) ? 10'($urandom_range(0, cap + 1)) : 10'($urandom),
                  1'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            issue(mhs_pkg::REQ_SORT, '0, '0, 1'b0);
            for (int j = 0; j < 3; j++)
                issue(mhs_pkg::REQ_READ, '0, 10'($urandom_range(0, cap)), 1'b0);
        end
    endtask

    initial begin
        int cap;
        issued = 0;
        calm = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = mhs_pkg::REQ_CLEAR;
        i_value = '0;
        i_index = '0;
        i_last_of_load = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small heap, full, sorted and index cases
        write_capacity(11'd4);
        issue(mhs_pkg::REQ_ADD, 32'sd3, '0, 1'b0);
        issue(mhs_pkg::REQ_CLEAR, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sh80000000, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sh7fffffff, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, -32'sd1, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sd0, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sd9, '0, 1'b1);
        issue(mhs_pkg::REQ_ADD, 32'sd5, '0, 1'b0);
        for (int j = 0; j < 5; j++) issue(mhs_pkg::REQ_READ, '0, 10'(j), 1'b0);
        issue(mhs_pkg::REQ_READ, '0, 10'h3ff, 1'b0);
        issue(mhs_pkg::REQ_SORT, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_ADD, 32'sd7, '0, 1'b0);
        issue(mhs_pkg::REQ_SORT, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_READ, '0, 10'd0, 1'b0);
        issue(3'd5, '1, '1, 1'b1);
        issue(3'd7, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_CLEAR, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sd2, '0, 1'b0);
        issue(mhs_pkg::REQ_SORT, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sd1, '0, 1'b1);
        write_capacity(11'd0);
        issue(mhs_pkg::REQ_CLEAR, '0, '0, 1'b0);
        issue(mhs_pkg::REQ_LOAD, 32'sd4, '0, 1'b1);
        issue(mhs_pkg::REQ_ADD, 32'sd4, '0, 1'b0);

        // capacity above depth acts as depth
        write_capacity(11'h7ff);
        issue(mhs_pkg::REQ_CLEAR, '0, '0, 1'b0);
        load_words(20);
        issue(mhs_pkg::REQ_ADD, pick_word(), '0, 1'b0);
        for (int j = 0; j < 8; j++) issue(mhs_pkg::REQ_READ, '0, 10'($urandom), 1'b0);
        issue(mhs_pkg::REQ_READ, '0, 10'h3ff, 1'b0);
        issue(mhs_pkg::REQ_CLEAR, '0, '0, 1'b0);
        write_capacity(11'd1024);
        for (int j = 0; j < 12; j++) issue(mhs_pkg::REQ_ADD, pick_word(), '0, 1'b0);
        issue(mhs_pkg::REQ_SORT, '0, '0, 1'b0);

        // random phases with small capacities, count may exceed a new capacity
        while (issued < ITEM_GOAL) begin
            cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
            write_capacity(11'(cap));
            if (issued > ITEM_GOAL - 100) calm = 1;
            repeat ($urandom_range(2, 6)) begin
                if (issued < ITEM_GOAL) random_round(cap);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
